// ===== rtl/nau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nau_pkg
// Shared codes, types and the sigmoid table generator of the activation unit.
// ----------------------------------------------------------------------------
package nau_pkg;

	// sigmoid value, unsigned Q1.16, 0 .. 65536
	typedef logic [16:0] sig_t;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_FUNC_SELECT = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEAK_FACTOR = 1'd1;

	localparam logic [1:0] FUNC_RELU    = 2'd0;
	localparam logic [1:0] FUNC_LEAKY   = 2'd1;
	localparam logic [1:0] FUNC_SIGMOID = 2'd2;
	localparam logic [1:0] FUNC_TANH    = 2'd3;

	localparam logic signed [16:0] ONE_Q12 = 17'sd4096;

	// shift-subtract division, used only while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] q;
		logic [63:0] r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= dvs) begin
				r = r - dvs;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// entry k of the table: round(65536 * sigmoid(-8 + 16k/nseg))
	function automatic sig_t sig_entry(input int unsigned k, input int unsigned nseg);
		longint      d;
		logic [63:0] m;
		logic [63:0] term;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] sp;
		d = longint'(16 * k) - longint'(8 * nseg);
		m = (d < 0) ? 64'(-d) : 64'(d);
		term = 64'h1_0000_0000;
		e = 64'd0;
		for (int n = 0; n < 400; n++) begin
			if (term != 64'd0) begin
				e = e + term;
				term = udiv64(term * m, 64'(nseg) * 64'(n + 1));
			end
		end
		den = e + 64'h1_0000_0000;
		sp = udiv64(e * 64'd65536 + (den >> 1), den);
		return (d < 0) ? sig_t'(64'd65536 - sp) : sig_t'(sp);
	endfunction

endpackage

// ===== rtl/nau_sig_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nau_sig_rom
// Sigmoid breakpoint table with two registered read ports.
// ----------------------------------------------------------------------------
module nau_sig_rom
	import nau_pkg::*;
#(
	parameter int SEGMENTS = 64,
	localparam int AW = $clog2(SEGMENTS + 1)
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] addr_lo,
	input  logic [AW-1:0] addr_hi,
	output sig_t          data_lo,
	output sig_t          data_hi
);

	sig_t rom_w [0:SEGMENTS];

	for (genvar g = 0; g <= SEGMENTS; g++) begin : g_entry
		localparam sig_t ENTRY = sig_entry(g, SEGMENTS);
		assign rom_w[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_lo <= rom_w[addr_lo];
			data_hi <= rom_w[addr_hi];
		end
	end

endmodule

// ===== rtl/neural_activation_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neural_activation_unit_top
// Elementwise relu, leaky relu, sigmoid and tanh, or their derivatives, on
// signed Q3.12 words.
//
// Input stream s_axis: tdata is the Q3.12 sample, tuser asks for the
// derivative, tlast marks the last word of a tensor. Output stream m_axis:
// tdata is the saturated Q3.12 result, tlast is copied from the input.
// The function and the leak slope are set through cfg_we / cfg_index /
// cfg_data while no word is in flight.
//
// Six register stages: index and leak product, table read, interpolation
// product, interpolation sum, derivative product, output register. One word
// per cycle is taken and delivered as long as m_axis_tready stays high.
// Reset empties every stage and selects relu with a zero leak slope.
// When the receiver stalls, the stages close up behind the output register
// and s_axis_tready drops only once all six stages hold a word; nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
module neural_activation_unit_top
	import nau_pkg::*;
#(
	parameter int TABLE_SEGMENTS = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [15:0]            s_axis_tdata,  // sample_value
	input  logic [0:0]             s_axis_tuser,  // want_derivative
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [15:0]            m_axis_tdata,  // result_value
	output logic                   m_axis_tlast
);

	localparam int AW = $clog2(TABLE_SEGMENTS + 1);
	localparam int PW = 16 + AW;
	localparam logic [AW-1:0] NSEG = AW'(TABLE_SEGMENTS);

	logic [1:0]  func_q;
	logic [15:0] leak_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic der_s1, der_s2, der_s3, der_s4, der_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	logic signed [15:0] x_s1;
	logic signed [32:0] leakp_s1;
	logic [AW-1:0]      idx_s1;
	logic               top_s1;
	logic [15:0]        frac_s1;

	logic signed [16:0] lin_s2, lin_s3, lin_s4, lin_s5;
	logic [15:0]        frac_s2;
	sig_t               lo_s2, hi_s2;

	sig_t               lo_s3;
	logic signed [34:0] ip_s3;

	sig_t               s_s4;

	sig_t               s_s5;
	logic signed [17:0] t_s5;
	logic signed [35:0] prod_s5;

	logic [15:0] data_s6;
	logic        last_s6;

	function automatic logic [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'h7fff;
		end else if (v < -20'sd32768) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	// stall control
	assign en6 = !v_s6 || m_axis_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = data_s6;
	assign m_axis_tlast  = last_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= FUNC_RELU;
			leak_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FUNC_SELECT: func_q <= cfg_data[1:0];
				REG_LEAK_FACTOR: leak_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: table index, fraction, leak product
	logic signed [15:0] x_in;
	logic signed [16:0] arg_w;
	logic signed [17:0] u_w;
	logic [PW-1:0]      p_w;
	logic [AW-1:0]      k_w;
	logic               top_w;

	always_comb begin
		x_in = $signed(s_axis_tdata);
		if (func_q == FUNC_TANH) begin
			arg_w = {x_in, 1'b0};
		end else begin
			arg_w = 17'(x_in);
		end
		if (arg_w < -17'sd32768) begin
			arg_w = -17'sd32768;
		end
		u_w   = 18'(arg_w) + 18'sd32768;
		top_w = u_w[16];
		p_w   = {{AW{1'b0}}, u_w[15:0]} * {16'd0, NSEG};
		k_w   = p_w[PW-1:16];
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1     <= x_in;
			der_s1   <= s_axis_tuser[0];
			last_s1  <= s_axis_tlast;
			top_s1   <= top_w;
			idx_s1   <= top_w ? NSEG : k_w;
			frac_s1  <= top_w ? 16'd0 : p_w[15:0];
			leakp_s1 <= 33'(x_in) * 33'($signed({1'b0, leak_q}));
		end
	end

	// stage 2: table read, relu and leaky relu
	logic signed [16:0] lin_w;
	logic signed [32:0] lk_rnd;
	logic [16:0]        leak_d;
	logic               pos_s1;

	always_comb begin
		pos_s1 = !x_s1[15] && (x_s1 != 16'sd0);
		lk_rnd = (33'sd32768 - leakp_s1) >>> 16;
		leak_d = ({1'b0, leak_q} + 17'd8) >> 4;
		case (func_q)
			FUNC_RELU: begin
				if (der_s1) begin
					lin_w = pos_s1 ? ONE_Q12 : 17'sd0;
				end else begin
					lin_w = pos_s1 ? 17'(x_s1) : 17'sd0;
				end
			end
			FUNC_LEAKY: begin
				if (der_s1) begin
					lin_w = pos_s1 ? ONE_Q12 : $signed(leak_d);
				end else begin
					lin_w = x_s1[15] ? -17'(lk_rnd) : 17'(x_s1);
				end
			end
			default: lin_w = 17'sd0;
		endcase
	end

	nau_sig_rom #(
		.SEGMENTS (TABLE_SEGMENTS)
	) u_rom (
		.clk     (clk),
		.en      (en2),
		.addr_lo (idx_s1),
		.addr_hi (top_s1 ? idx_s1 : idx_s1 + AW'(1)),
		.data_lo (lo_s2),
		.data_hi (hi_s2)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			der_s2  <= der_s1;
			last_s2 <= last_s1;
			frac_s2 <= frac_s1;
			lin_s2  <= lin_w;
		end
	end

	// stage 3: interpolation product
	logic signed [17:0] diff_w;

	assign diff_w = $signed({1'b0, hi_s2}) - $signed({1'b0, lo_s2});

	always_ff @(posedge clk) begin
		if (en3) begin
			der_s3  <= der_s2;
			last_s3 <= last_s2;
			lin_s3  <= lin_s2;
			lo_s3   <= lo_s2;
			ip_s3   <= 35'(diff_w) * 35'($signed({1'b0, frac_s2}));
		end
	end

	// stage 4: interpolation sum
	logic signed [34:0] ip_mag;
	logic signed [34:0] ip_rnd;
	logic signed [18:0] s_w;

	always_comb begin
		ip_mag = ip_s3[34] ? -ip_s3 : ip_s3;
		ip_rnd = (ip_mag + 35'sd32768) >>> 16;
		if (ip_s3[34]) begin
			ip_rnd = -ip_rnd;
		end
		s_w = $signed({2'b00, lo_s3}) + 19'(ip_rnd);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			der_s4  <= der_s3;
			last_s4 <= last_s3;
			lin_s4  <= lin_s3;
			s_s4    <= s_w[16:0];
		end
	end

	// stage 5: tanh value and derivative product
	logic signed [18:0] t_w;
	logic signed [17:0] op_a, op_b;

	always_comb begin
		t_w = $signed({1'b0, s_s4, 1'b0}) - 19'sd65536;
		if (func_q == FUNC_TANH) begin
			op_a = t_w[17:0];
			op_b = t_w[17:0];
		end else begin
			op_a = $signed({1'b0, s_s4});
			op_b = 18'sd65536 - $signed({1'b0, s_s4});
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			der_s5  <= der_s4;
			last_s5 <= last_s4;
			lin_s5  <= lin_s4;
			s_s5    <= s_s4;
			t_s5    <= t_w[17:0];
			prod_s5 <= 36'(op_a) * 36'(op_b);
		end
	end

	// stage 6: rounding, selection, saturation
	logic [12:0]        sig_act;
	logic [15:0]        sig_der;
	logic [36:0]        tanh_tmp;
	logic [16:0]        tanh_der;
	logic signed [18:0] t_ext, t_mag, t_rnd;
	logic signed [19:0] res_w;

	always_comb begin
		sig_act  = 13'(({1'b0, s_s5} + 18'd8) >> 4);
		sig_der  = 16'(({1'b0, prod_s5} + 37'd524288) >> 20);
		tanh_tmp = 37'h1_0000_0000 - {1'b0, prod_s5} + 37'd524288;
		tanh_der = 17'(tanh_tmp >> 20);
		t_ext    = 19'(t_s5);
		t_mag    = t_s5[17] ? -t_ext : t_ext;
		t_rnd    = (t_mag + 19'sd8) >>> 4;
		if (t_s5[17]) begin
			t_rnd = -t_rnd;
		end
		case (func_q)
			FUNC_RELU, FUNC_LEAKY: res_w = 20'(lin_s5);
			FUNC_SIGMOID: begin
				res_w = der_s5 ? $signed({4'd0, sig_der}) : $signed({7'd0, sig_act});
			end
			FUNC_TANH: begin
				res_w = der_s5 ? $signed({3'd0, tanh_der}) : 20'(t_rnd);
			end
			default: res_w = 20'sd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			data_s6 <= sat16(res_w);
			last_s6 <= last_s5;
		end
	end

	// checks
	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input stalled with an empty stage");

	a_stall_keeps_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !m_axis_tready && v_s5) |=> (v_s5 && $stable(s_s5) && $stable(lin_s5)))
		else $error("stage 5 word lost during output stall");

	a_sigmoid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (s_s4 <= 17'd65536))
		else $error("interpolated sigmoid above one");

	a_sig_prod_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && func_q == FUNC_SIGMOID) |-> !prod_s5[35])
		else $error("sigmoid derivative product negative");

endmodule
